FILE: hw/rtl/lca_pkg.sv
// Shared types and constants for the common-ancestor block.
package lca_pkg;

  localparam int unsigned IdW = 17;
  localparam logic [IdW-1:0] DepthMax = '1;

  typedef logic [IdW-1:0] id_t;

  // Datapath commands issued by the controller.
  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,      // capture request fields, clip ids
    CMD_RD_PDEP,   // read depth of parent
    CMD_WR_BASE,   // write depth and level 0
    CMD_RD_LVL,    // read jump of cursor at level
    CMD_WR_LVL,    // write fill value at level
    CMD_RD_DEP,    // read depth of node a and b
    CMD_LIFT_RD,   // read jump of y at level
    CMD_LIFT_UP,   // conditional lift of y
    CMD_BOTH_RD,   // read jump of x; BOTH_RD2 reads y
    CMD_BOTH_RD2,
    CMD_BOTH_UP,   // conditional lift of both
    CMD_FINAL_RD,  // read jump of x at level 0
    CMD_FINAL      // latch answer
  } cmd_e;

  typedef struct packed {
    cmd_e        cmd;
    logic [4:0]  level;
    logic        sel_b;   // which depth read phase
  } ctrl_t;

  typedef struct packed {
    logic is_query;
    logic node_zero;
    logic same;           // x equals y
  } stat_t;

endpackage

FILE: hw/rtl/lca_if.sv
// Valid/ready channel interfaces for request and result words.
interface lca_req_if;
  logic                 valid;
  logic                 ready;
  logic                 req_type;
  logic [lca_pkg::IdW-1:0] node_id;
  logic [lca_pkg::IdW-1:0] parent_id;
  logic [lca_pkg::IdW-1:0] node_a;
  logic [lca_pkg::IdW-1:0] node_b;
  modport source (output valid, req_type, node_id, parent_id, node_a, node_b, input ready);
  modport sink (input valid, req_type, node_id, parent_id, node_a, node_b, output ready);
endinterface

interface lca_rsp_if;
  logic                 valid;
  logic                 ready;
  logic                 answered;
  logic [lca_pkg::IdW-1:0] ancestor;
  modport source (output valid, answered, ancestor, input ready);
  modport sink (input valid, answered, ancestor, output ready);
endinterface

FILE: hw/rtl/lca_datapath.sv
// Datapath: tables, cursors and the depth compare for adds and queries.
module lca_datapath #(
  parameter int unsigned NodeCount = 131072,
  parameter int unsigned Levels    = 17
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  lca_pkg::ctrl_t        ctrl_i,
  input  logic                  req_type_i,
  input  lca_pkg::id_t          node_id_i,
  input  lca_pkg::id_t          parent_id_i,
  input  lca_pkg::id_t          node_a_i,
  input  lca_pkg::id_t          node_b_i,
  output lca_pkg::stat_t        stat_o,
  output lca_pkg::id_t          answer_o
);
  localparam int unsigned NW = (NodeCount > 1) ? $clog2(NodeCount) : 1;
  localparam int unsigned LW = (Levels > 1) ? $clog2(Levels) : 1;

  lca_pkg::id_t jump_mem [NodeCount*Levels];
  lca_pkg::id_t depth_mem [NodeCount];

  lca_pkg::id_t x_q, y_q, v_q, par_q, cur_q, ax_q, jrd_q, drd_q, dx_q, ans_q;
  logic is_q_q, zero_q;

  // Ids at or above the node count stand for the sentinel.
  function automatic lca_pkg::id_t clip(lca_pkg::id_t raw);
    clip = (32'(raw) < NodeCount) ? raw : '0;
  endfunction

  function automatic logic [NW+LW-1:0] jaddr(lca_pkg::id_t n, logic [4:0] k);
    jaddr = (NW+LW)'((32'(n[NW-1:0]) * Levels) + 32'(k));
  endfunction

  logic [LW-1:0] lvl;
  assign lvl = LW'(ctrl_i.level);

  // The first lift read swaps the nodes when x turns out to be deeper.
  logic lift_swap;
  assign lift_swap = (ctrl_i.level == 5'(Levels - 1)) && (dx_q > drd_q);

  // Jump read address: node 0 reads as zero via the zero mux below.
  lca_pkg::id_t rd_node;
  always_comb begin
    case (ctrl_i.cmd)
      lca_pkg::CMD_RD_LVL:   rd_node = cur_q;
      lca_pkg::CMD_LIFT_RD:  rd_node = lift_swap ? x_q : y_q;
      lca_pkg::CMD_BOTH_RD:  rd_node = x_q;
      lca_pkg::CMD_BOTH_RD2: rd_node = y_q;
      lca_pkg::CMD_FINAL_RD: rd_node = x_q;
      default:               rd_node = cur_q;
    endcase
  end

  logic rd_zero_q, drd_zero_q;
  lca_pkg::id_t jmem_q, dmem_q;
  lca_pkg::id_t d_node;
  always_comb begin
    case (ctrl_i.cmd)
      lca_pkg::CMD_RD_PDEP: d_node = par_q;
      lca_pkg::CMD_RD_DEP:  d_node = ctrl_i.sel_b ? y_q : x_q;
      lca_pkg::CMD_LIFT_RD: d_node = rd_node;
      default:              d_node = par_q;
    endcase
  end

  // Registered memory reads.
  always_ff @(posedge clk_i) begin
    jmem_q     <= jump_mem[jaddr(rd_node, 5'(lvl))];
    rd_zero_q  <= (rd_node == '0);
    dmem_q     <= depth_mem[d_node[NW-1:0]];
    drd_zero_q <= (d_node == '0);
  end
  always_comb begin
    jrd_q = rd_zero_q ? '0 : jmem_q;
    drd_q = drd_zero_q ? '0 : dmem_q;
  end

  // Memory writes for adds; node 0 is never written.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.cmd == lca_pkg::CMD_WR_BASE && !zero_q) begin
      depth_mem[v_q[NW-1:0]] <= (drd_q == lca_pkg::DepthMax) ? drd_q
                                                             : drd_q + lca_pkg::id_t'(1);
      jump_mem[jaddr(v_q, 5'd0)] <= par_q;
    end
    if (ctrl_i.cmd == lca_pkg::CMD_WR_LVL && !zero_q) begin
      jump_mem[jaddr(v_q, 5'(lvl))] <= jrd_q;
    end
  end

  // Depth gap between the current y, read with its jump, and x.
  localparam int unsigned IdWm = lca_pkg::IdW - 1;
  logic [IdWm:0] diff;
  assign diff = drd_q - dx_q;

  // Cursor registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      is_q_q <= 1'b0;
      zero_q <= 1'b0;
    end else if (ctrl_i.cmd == lca_pkg::CMD_LOAD) begin
      is_q_q <= req_type_i;
      zero_q <= (clip(node_id_i) == '0);
    end
  end

  always_ff @(posedge clk_i) begin
    case (ctrl_i.cmd)
      lca_pkg::CMD_LOAD: begin
        v_q   <= clip(node_id_i);
        par_q <= clip(parent_id_i);
        cur_q <= clip(parent_id_i);
        x_q   <= clip(node_a_i);
        y_q   <= clip(node_b_i);
        ans_q <= '0;
      end
      lca_pkg::CMD_WR_LVL: cur_q <= jrd_q;
      lca_pkg::CMD_WR_BASE: cur_q <= par_q;
      lca_pkg::CMD_RD_DEP: begin
        // Depth of x arrives on the phase after its read.
        if (ctrl_i.sel_b) dx_q <= drd_q;
      end
      lca_pkg::CMD_LIFT_RD: begin
        // Last depth read lands here; order so y is deeper.
        if (lift_swap) begin
          x_q <= y_q; y_q <= x_q; dx_q <= drd_q;
        end
      end
      lca_pkg::CMD_LIFT_UP: begin
        if (drd_q >= dx_q && 32'(diff) >= (32'd1 << ctrl_i.level)) begin
          y_q <= jrd_q;
        end
      end
      lca_pkg::CMD_BOTH_RD2: ax_q <= jrd_q;
      lca_pkg::CMD_BOTH_UP: begin
        if (ax_q != jrd_q) begin
          x_q <= ax_q; y_q <= jrd_q;
        end
      end
      lca_pkg::CMD_FINAL: ans_q <= (x_q == y_q) ? x_q : jrd_q;
      default: ;
    endcase
  end

  assign stat_o.is_query  = is_q_q;
  assign stat_o.node_zero = zero_q;
  assign stat_o.same      = (x_q == y_q);
  assign answer_o         = ans_q;
endmodule

FILE: hw/rtl/lca_ctrl.sv
// Controller: sequences add fills, depth reads and the two lift passes.
module lca_ctrl #(
  parameter int unsigned Levels = 17
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  lca_pkg::stat_t stat_i,
  output lca_pkg::ctrl_t ctrl_o
);
  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_PDEP  = 10'b0000000010,
    S_BASE  = 10'b0000000100,
    S_FILL  = 10'b0000001000,
    S_DEPA  = 10'b0000010000,
    S_LIFT  = 10'b0000100000,
    S_BOTH  = 10'b0001000000,
    S_FIN   = 10'b0010000000,
    S_DONE  = 10'b0100000000,
    S_OUT   = 10'b1000000000
  } state_e;

  state_e state_q, state_d;
  logic [4:0] lvl_q, lvl_d;
  logic [1:0] ph_q, ph_d;

  localparam logic [4:0] Top = 5'(Levels - 1);

  // Next-state and command generation.
  always_comb begin
    state_d = state_q;
    lvl_d   = lvl_q;
    ph_d    = ph_q;
    ctrl_o  = '{cmd: lca_pkg::CMD_NONE, level: lvl_q, sel_b: 1'b0};
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctrl_o.cmd = lca_pkg::CMD_LOAD;
          state_d = S_DEPA;
          ph_d = 2'd0;
        end
      end
      S_DEPA: begin
        if (!stat_i.is_query) begin
          ctrl_o.cmd = lca_pkg::CMD_RD_PDEP;
          state_d = S_BASE;
        end else if (ph_q == 2'd0) begin
          ctrl_o.cmd = lca_pkg::CMD_RD_DEP; ph_d = 2'd1;
        end else if (ph_q == 2'd1) begin
          ctrl_o.cmd = lca_pkg::CMD_RD_DEP; ctrl_o.sel_b = 1'b1; ph_d = 2'd2;
        end else begin
          // Depth of y lands as the first lift read issues.
          ctrl_o.cmd = lca_pkg::CMD_LIFT_RD; ctrl_o.level = Top;
          lvl_d = Top; ph_d = 2'd1; state_d = S_LIFT;
        end
      end
      S_PDEP: state_d = S_BASE;
      S_BASE: begin
        ctrl_o.cmd = lca_pkg::CMD_WR_BASE;
        lvl_d = 5'd0; ph_d = 2'd0;
        state_d = (Levels > 1) ? S_FILL : S_OUT;
      end
      S_FILL: begin
        // Two jumps of level k-1 give level k; the cursor holds the first.
        ctrl_o.level = lvl_q;
        if (ph_q == 2'd0) begin
          ctrl_o.cmd = lca_pkg::CMD_RD_LVL; ph_d = 2'd1;
        end else begin
          ctrl_o.cmd = lca_pkg::CMD_WR_LVL; ph_d = 2'd0;
          if (ph_q == 2'd1) begin
            ph_d = 2'd2;
          end else begin
            ctrl_o.level = lvl_q + 5'd1;
            lvl_d = lvl_q + 5'd1;
            if (lvl_q + 5'd1 == Top) state_d = S_OUT;
          end
        end
        if (ph_q == 2'd1) ctrl_o.cmd = lca_pkg::CMD_NONE;
      end
      S_LIFT: begin
        if (ph_q == 2'd0) begin
          ctrl_o.cmd = lca_pkg::CMD_LIFT_RD; ctrl_o.level = Top; ph_d = 2'd1;
        end else begin
          ctrl_o.cmd = lca_pkg::CMD_LIFT_UP; ph_d = 2'd0;
          if (lvl_q == 5'd0) begin
            state_d = S_BOTH; lvl_d = Top;
          end else begin
            lvl_d = lvl_q - 5'd1;
          end
        end
        if (ph_q == 2'd0) ctrl_o.level = lvl_q;
      end
      S_BOTH: begin
        if (stat_i.same && ph_q == 2'd0) begin
          state_d = S_DONE;
        end else if (ph_q == 2'd0) begin
          ctrl_o.cmd = lca_pkg::CMD_BOTH_RD; ph_d = 2'd1;
        end else if (ph_q == 2'd1) begin
          ctrl_o.cmd = lca_pkg::CMD_BOTH_RD2; ph_d = 2'd2;
        end else if (ph_q == 2'd2) begin
          ctrl_o.cmd = lca_pkg::CMD_BOTH_UP; ph_d = 2'd3;
        end
        if (ph_q == 2'd3) begin
          ph_d = 2'd0;
          if (lvl_q == 5'd0) state_d = S_FIN;
          else lvl_d = lvl_q - 5'd1;
        end
      end
      S_FIN: begin
        ctrl_o.cmd = lca_pkg::CMD_FINAL_RD; ctrl_o.level = 5'd0;
        state_d = S_DONE;
      end
      S_DONE: begin
        ctrl_o.cmd = lca_pkg::CMD_FINAL; ctrl_o.level = 5'd0;
        state_d = S_OUT;
      end
      S_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      lvl_q   <= '0;
      ph_q    <= '0;
    end else begin
      state_q <= state_d;
      lvl_q   <= lvl_d;
      ph_q    <= ph_d;
    end
  end
endmodule

FILE: hw/rtl/lca_binary_lifting.sv
// Top level of the binary-lifting common-ancestor block.
//  channel | dir | fields
//  req     | in  | req_type, node_id, parent_id, node_a, node_b
//  rsp     | out | answered, ancestor
// One word is in flight at a time, and the single jump-table read port sets how long an
// add or a query takes; a query whose nodes meet in the first lift pass skips the second.
// Reset is asynchronous, active low, and clears only control state.
// A stalled result holds the block until it is taken.
module lca_binary_lifting #(
  parameter int unsigned NODE_COUNT = 131072,
  parameter int unsigned LEVELS     = 17
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  lca_req_if.sink   req,
  lca_rsp_if.source rsp
);
  lca_pkg::ctrl_t ctrl;
  lca_pkg::stat_t stat;
  lca_pkg::id_t   answer;

  lca_ctrl #(.Levels(LEVELS)) u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(req.valid), .in_ready_o(req.ready),
    .out_valid_o(rsp.valid), .out_ready_i(rsp.ready),
    .stat_i(stat), .ctrl_o(ctrl)
  );

  lca_datapath #(.NodeCount(NODE_COUNT), .Levels(LEVELS)) u_dp (
    .clk_i, .rst_ni, .ctrl_i(ctrl),
    .req_type_i(req.req_type), .node_id_i(req.node_id),
    .parent_id_i(req.parent_id), .node_a_i(req.node_a), .node_b_i(req.node_b),
    .stat_o(stat), .answer_o(answer)
  );

  assign rsp.answered = stat.is_query;
  assign rsp.ancestor = stat.is_query ? answer : '0;
endmodule

FILE: dv/lca_binary_lifting_tb.sv
// Testbench for the binary-lifting common-ancestor block: directed and random tree traffic.
module lca_binary_lifting_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Nodes  = 131072;
  localparam int unsigned Levels = 17;
  localparam logic        ReqAdd   = 1'b0;
  localparam logic        ReqQuery = 1'b1;

  typedef struct packed {
    logic         answered;
    lca_pkg::id_t ancestor;
  } answer_t;

  logic clk_i;
  logic rst_ni;

  lca_req_if req ();
  lca_rsp_if rsp ();

  lca_binary_lifting #(
    .NODE_COUNT(Nodes),
    .LEVELS    (Levels)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req   (req),
    .rsp   (rsp)
  );

  // Shadow copy of the tree tables; missing entries read as zero.
  lca_pkg::id_t depth_mem[int];
  lca_pkg::id_t jump_mem[int];
  // Nodes added so far, in order of adding.
  lca_pkg::id_t tree_nodes[$];
  answer_t answers_due[$];

  int errors;
  int src_idle_pct;
  int snk_idle_pct;
  int stall_ask;
  int stall_left;

  // Clock with a 10 ns period.
  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic lca_pkg::id_t clip(lca_pkg::id_t raw);
    return (raw < Nodes) ? raw : '0;
  endfunction

  function automatic lca_pkg::id_t depth_of(lca_pkg::id_t v);
    return depth_mem.exists(v) ? depth_mem[v] : '0;
  endfunction

  function automatic lca_pkg::id_t jump_of(lca_pkg::id_t v, int k);
    int key;
    key = int'(v) * Levels + k;
    return jump_mem.exists(key) ? jump_mem[key] : '0;
  endfunction

  // Store depth and every jump level of a newly added node.
  function automatic void tree_add(lca_pkg::id_t v, lca_pkg::id_t par);
    lca_pkg::id_t d;
    if (v == '0) return;
    d = depth_of(par);
    depth_mem[v] = (d >= lca_pkg::DepthMax) ? lca_pkg::DepthMax : d + lca_pkg::id_t'(1);
    jump_mem[int'(v) * Levels] = par;
    for (int k = 1; k < Levels; k++) begin
      jump_mem[int'(v) * Levels + k] = jump_of(jump_of(v, k - 1), k - 1);
    end
  endfunction

  // Lift the deeper node, then both, and return the common ancestor.
  function automatic lca_pkg::id_t tree_lca(lca_pkg::id_t a, lca_pkg::id_t b);
    lca_pkg::id_t x;
    lca_pkg::id_t y;
    lca_pkg::id_t t;
    lca_pkg::id_t ax;
    lca_pkg::id_t ay;
    x = a;
    y = b;
    if (depth_of(x) > depth_of(y)) begin
      t = x;
      x = y;
      y = t;
    end
    for (int k = Levels - 1; k >= 0; k--) begin
      if (depth_of(y) >= depth_of(x) && (depth_of(y) - depth_of(x)) >= (32'd1 << k)) begin
        y = jump_of(y, k);
      end
    end
    if (x == y) return x;
    for (int k = Levels - 1; k >= 0; k--) begin
      ax = jump_of(x, k);
      ay = jump_of(y, k);
      if (ax != ay) begin
        x = ax;
        y = ay;
      end
    end
    return jump_of(x, 0);
  endfunction

  // Offer one word, wait until it is taken, then predict its answer.
  task automatic send_word(logic kind, lca_pkg::id_t nid, lca_pkg::id_t pid,
                           lca_pkg::id_t na, lca_pkg::id_t nb);
    answer_t due;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      req.valid <= 1'b0;
      @(posedge clk_i);
    end
    req.valid     <= 1'b1;
    req.req_type  <= kind;
    req.node_id   <= nid;
    req.parent_id <= pid;
    req.node_a    <= na;
    req.node_b    <= nb;
    @(posedge clk_i);
    while (!req.ready) @(posedge clk_i);
    if (kind == ReqAdd) begin
      tree_add(clip(nid), clip(pid));
      due = '{answered: 1'b0, ancestor: '0};
    end else begin
      due = '{answered: 1'b1, ancestor: tree_lca(clip(na), clip(nb))};
    end
    answers_due.insert(answers_due.size(), due);
  endtask

  task automatic add_node(lca_pkg::id_t nid, lca_pkg::id_t pid);
    send_word(ReqAdd, nid, pid, lca_pkg::id_t'($urandom), lca_pkg::id_t'($urandom));
    if (nid != '0) tree_nodes.insert(tree_nodes.size(), nid);
  endtask

  task automatic ask_lca(lca_pkg::id_t na, lca_pkg::id_t nb);
    send_word(ReqQuery, lca_pkg::id_t'($urandom), lca_pkg::id_t'($urandom), na, nb);
  endtask

  function automatic lca_pkg::id_t pick_node();
    return tree_nodes[$urandom_range(0, tree_nodes.size() - 1)];
  endfunction

  task automatic report_mismatch(string what, lca_pkg::id_t got, lca_pkg::id_t want);
    $display("mismatch %s: got %0d, expected %0d", what, got, want);
    errors++;
  endtask

  // Receiver: random holds, plus a long hold when a test asks for it.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp.ready  <= 1'b0;
      stall_left  = 0;
    end else begin
      if (stall_ask != 0) begin
        stall_left = stall_ask;
        stall_ask  = 0;
      end
      if (stall_left > 0) begin
        stall_left--;
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
      end
    end
  end

  // Compare each taken result word with the oldest prediction.
  always @(posedge clk_i) begin
    answer_t due;
    if (rst_ni && rsp.valid && rsp.ready) begin
      if (answers_due.size() == 0) begin
        report_mismatch("unexpected word", rsp.ancestor, '0);
      end else begin
        due = answers_due.pop_front();
        if (rsp.answered !== due.answered) begin
          report_mismatch("answered", lca_pkg::id_t'(rsp.answered),
                          lca_pkg::id_t'(due.answered));
        end
        if (rsp.ancestor !== due.ancestor) begin
          report_mismatch("ancestor", rsp.ancestor, due.ancestor);
        end
      end
    end
  end

  // Small tree with extreme ids, a chain, siblings and an ignored add of node 0.
  task automatic test_directed();
    add_node(17'd1, 17'd0);
    add_node(17'h1FFFF, 17'd1);
    add_node(17'd2, 17'd1);
    for (int i = 3; i <= 12; i++) add_node(lca_pkg::id_t'(i), lca_pkg::id_t'(i - 1));
    add_node(17'd0, 17'd5);
    ask_lca(17'h1FFFF, 17'd12);
    ask_lca(17'd12, 17'd4);
    ask_lca(17'd4, 17'd12);
    ask_lca(17'd1, 17'd1);
    ask_lca(17'd12, 17'd11);
    ask_lca(17'h1FFFF, 17'h1FFFF);
    ask_lca(17'd2, 17'h1FFFF);
  endtask

  // Grow the tree at random, mixing deep chains, re-adds and queries.
  task automatic test_random_tree(int count);
    int roll;
    for (int i = 0; i < count; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < 25) begin
        add_node(lca_pkg::id_t'($urandom_range(1, Nodes - 1)), tree_nodes[$]);
      end else if (roll < 40) begin
        add_node(lca_pkg::id_t'($urandom_range(1, Nodes - 1)), pick_node());
      end else if (roll < 43) begin
        add_node(pick_node(), pick_node());
      end else if (roll < 45) begin
        add_node(17'd0, pick_node());
      end else if (roll < 47) begin
        add_node(lca_pkg::id_t'($urandom_range(1, Nodes - 1)), 17'd0);
      end else begin
        ask_lca(pick_node(), pick_node());
      end
    end
  endtask

  // Hold the result side for a long time while words keep coming.
  task automatic test_backpressure();
    src_idle_pct = 0;
    snk_idle_pct = 0;
    stall_ask    = 3000;
    for (int i = 0; i < 20; i++) begin
      if (i % 2 == 0) ask_lca(pick_node(), pick_node());
      else add_node(lca_pkg::id_t'($urandom_range(1, Nodes - 1)), pick_node());
    end
  endtask

  initial begin
    errors       = 0;
    stall_ask    = 0;
    src_idle_pct = 11;
    snk_idle_pct = 53;
    rst_ni        = 1'b0;
    req.valid     = 1'b0;
    req.req_type  = ReqAdd;
    req.node_id   = '0;
    req.parent_id = '0;
    req.node_a    = '0;
    req.node_b    = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random_tree(330);
    src_idle_pct = 53;
    snk_idle_pct = 11;
    test_random_tree(330);
    test_backpressure();
    src_idle_pct = 0;
    snk_idle_pct = 0;
    test_random_tree(330);
    req.valid <= 1'b0;

    while (answers_due.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Run limit, far above the slowest legal run.
  initial begin
    #40ms;
    $display("simulation failed");
    $finish;
  end

endmodule
